@@ hdl/qalu_pkg.sv @@
// Package for the quaternion ALU: command codes, widths, shared helpers.
// Used by every module under hdl.
package qalu_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [3:0] {
      CMD_ADD    = 4'd0,
      CMD_A_SUB  = 4'd1,
      CMD_B_SUB  = 4'd2,
      CMD_AB_MUL = 4'd3,
      CMD_BA_MUL = 4'd4,
      CMD_DOT    = 4'd5,
      CMD_CONJ_A = 4'd6,
      CMD_CONJ_B = 4'd7,
      CMD_MAG_A  = 4'd8,
      CMD_MAG_B  = 4'd9,
      CMD_INV_A  = 4'd10,
      CMD_INV_B  = 4'd11,
      CMD_SCL_A  = 4'd12,
      CMD_SCL_B  = 4'd13,
      CMD_NOP_E  = 4'd14,
      CMD_NOP_F  = 4'd15
   } cmd_type;

   // Result kind used by the merge stage.
   typedef enum logic [2:0] {
      KIND_ZERO  = 3'd0,
      KIND_LIN   = 3'd1,
      KIND_PROD  = 3'd2,
      KIND_DOT   = 3'd3,
      KIND_MAG   = 3'd4,
      KIND_INV   = 3'd5
   } kind_type;

endpackage

@@ hdl/qalu_lane.sv @@
// One product lane: four signed products, each registered, then an exact
// sum rounded to nearest (ties up) and saturated. Depends on qalu_pkg.
module qalu_lane #(
   parameter int WORD_WIDTH = qalu_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         adv_0,
   input  logic                         adv_1,
   input  logic signed [WORD_WIDTH-1:0] x [4],
   input  logic signed [WORD_WIDTH-1:0] y [4],
   input  logic        [3:0]            neg,
   output logic signed [WORD_WIDTH-1:0] sum_ff
);
   localparam int PW = 2 * WORD_WIDTH;
   localparam int SW = PW + 3;
   localparam logic signed [SW-FRAC_BITS-1:0] HI =
      (SW-FRAC_BITS)'({1'b0, {(WORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-FRAC_BITS-1:0] LO = -HI - 1;

   logic signed [PW-1:0] prod_ff [4];
   logic signed [SW-1:0] acc;
   logic signed [SW-1:0] rnd;
   logic signed [SW-FRAC_BITS-1:0] shf;
   logic signed [WORD_WIDTH-1:0] sum_in;

   always_ff @(posedge clock) begin
      for (int n = 0; n < 4; n++) begin
         if (adv_0) begin
            prod_ff[n] <= x[n] * y[n];
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int n = 0; n < 4; n++) begin
         if (neg[n]) begin
            acc = acc - SW'(prod_ff[n]);
         end else begin
            acc = acc + SW'(prod_ff[n]);
         end
      end
      rnd = acc + (SW'(1) <<< (FRAC_BITS - 1));
      shf = rnd[SW-1:FRAC_BITS];
      if (shf > HI) begin
         sum_in = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end else if (shf < LO) begin
         sum_in = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
         sum_in = shf[WORD_WIDTH-1:0];
      end
   end

   // neg must follow the products; caller holds it one stage
   always_ff @(posedge clock) begin
      if (adv_1) begin
         sum_ff <= sum_in;
      end
   end
endmodule

@@ hdl/qalu_sqrt.sv @@
// Pipelined restoring square root of the norm squared, one result bit per
// stage, rounded to nearest. Depends on qalu_pkg.
module qalu_sqrt #(
   parameter int WORD_WIDTH = qalu_pkg::WORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic [WORD_WIDTH+1:0] adv,
   input  logic [2*WORD_WIDTH+1:0] rad,
   output logic [WORD_WIDTH:0]   root_ff
);
   localparam int NW = 2 * WORD_WIDTH + 2;
   localparam int RW = WORD_WIDTH + 1;
   localparam int STAGES = RW + 1;

   logic [NW-1:0] x_ff   [STAGES];
   logic [NW-1:0] rem_ff [STAGES];
   logic [RW-1:0] res_ff [STAGES];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0]   <= rad;
         rem_ff[0] <= '0;
         res_ff[0] <= '0;
      end
      for (int s = 0; s < RW; s++) begin
         if (adv[s+1]) begin
            logic [NW-1:0] r2;
            logic [NW-1:0] trial;
            r2    = {rem_ff[s][NW-3:0], x_ff[s][NW-1:NW-2]};
            trial = NW'({res_ff[s], 2'b01});
            x_ff[s+1] <= {x_ff[s][NW-3:0], 2'b00};
            if (r2 >= trial) begin
               rem_ff[s+1] <= r2 - trial;
               res_ff[s+1] <= {res_ff[s][RW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= r2;
               res_ff[s+1] <= {res_ff[s][RW-2:0], 1'b0};
            end
         end
      end
   end

   // round: remainder beyond root means the fraction is above one half
   always_comb begin
      if (rem_ff[STAGES-1] > NW'(res_ff[STAGES-1])) begin
         root_ff = res_ff[STAGES-1] + RW'(1);
      end else begin
         root_ff = res_ff[STAGES-1];
      end
   end
endmodule

@@ hdl/qalu_div.sv @@
// Pipelined restoring divider for one inverse component: magnitude times
// 2^(2F) over the norm, one quotient bit per stage. Depends on qalu_pkg.
module qalu_div #(
   parameter int WORD_WIDTH = qalu_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic [WORD_WIDTH+2*FRAC_BITS+1:0] adv,
   input  logic [WORD_WIDTH:0]    num,
   input  logic [2*WORD_WIDTH+1:0] den,
   output logic [WORD_WIDTH-1:0]  quo_mag
);
   localparam int DW = 2 * WORD_WIDTH + 2;
   localparam int QB = WORD_WIDTH + 2 * FRAC_BITS + 1;
   localparam int STAGES = QB + 1;
   localparam int RWD = DW + 1;

   logic [QB-1:0]  nsh_ff [STAGES];
   logic [RWD-1:0] rem_ff [STAGES];
   logic [QB-1:0]  quo_ff [STAGES];
   logic [DW-1:0]  den_ff [STAGES];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         nsh_ff[0] <= QB'(num) << (2 * FRAC_BITS);
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         den_ff[0] <= den;
      end
      for (int s = 0; s < QB; s++) begin
         if (adv[s+1]) begin
            logic [RWD-1:0] r2;
            r2 = {rem_ff[s][RWD-2:0], nsh_ff[s][QB-1]};
            nsh_ff[s+1] <= {nsh_ff[s][QB-2:0], 1'b0};
            den_ff[s+1] <= den_ff[s];
            if (r2 >= RWD'(den_ff[s])) begin
               rem_ff[s+1] <= r2 - RWD'(den_ff[s]);
               quo_ff[s+1] <= {quo_ff[s][QB-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= r2;
               quo_ff[s+1] <= {quo_ff[s][QB-2:0], 1'b0};
            end
         end
      end
   end

   logic [QB:0] q_rnd;
   always_comb begin
      logic [RWD:0] r2x;
      r2x = {rem_ff[STAGES-1], 1'b0};
      q_rnd = {1'b0, quo_ff[STAGES-1]};
      if (r2x >= (RWD+1)'(den_ff[STAGES-1])) begin
         q_rnd = q_rnd + (QB+1)'(1);
      end
      if (q_rnd > (QB+1)'({WORD_WIDTH{1'b1}})) begin
         quo_mag = {WORD_WIDTH{1'b1}};
      end else begin
         quo_mag = q_rnd[WORD_WIDTH-1:0];
      end
   end
endmodule

@@ hdl/quaternion_alu.sv @@
// Quaternion ALU, fully pipelined: one item accepted per cycle while the
// output is not held; the whole pipe stalls as one when it is. Latency is
// set by the inverse divider pipeline. Default operands are Q16.16. Four
// product lanes and a norm lane feed a merge stage. Reset (synchronous)
// clears the valid bits only.
module quaternion_alu #(
   parameter int WORD_WIDTH = qalu_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // low to high: a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scale_factor
   input  logic [9*WORD_WIDTH-1:0]  req_tdata,
   // command
   input  logic [3:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // low to high: r_real, r_i, r_j, r_k, scalar_out
   output logic [5*WORD_WIDTH-1:0]  rsp_tdata,
   // div_error
   output logic                     rsp_tuser
);
   localparam int W  = WORD_WIDTH;
   localparam int NW = 2 * W + 2;
   localparam int DST = W + 2 * FRAC_BITS + 2;
   localparam int SST = W + 2;
   localparam int LAT = 3 + DST;
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic               vld;
      qalu_pkg::kind_type kind;
      logic [W-1:0]       lin0, lin1, lin2, lin3;
      logic               big;
      logic               zero;
      logic [3:0]         neg;
      logic [3:0]         nz;
   } ctl_type;

   ctl_type ctl_ff [LAT];
   logic adv;
   logic [LAT-1:0] adv_v;

   assign adv = !ctl_ff[LAT-1].vld || rsp_tready;
   assign adv_v = {LAT{adv}};
   assign req_tready = adv;

   logic signed [W-1:0] a [4], b [4], s;
   qalu_pkg::cmd_type cmd;
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         a[n] = req_tdata[n*W +: W];
         b[n] = req_tdata[(n+4)*W +: W];
      end
      s = req_tdata[8*W +: W];
      cmd = qalu_pkg::cmd_type'(req_tuser);
   end

   function automatic logic signed [W-1:0] sat1(input logic signed [W:0] v);
      if (v > (W+1)'(SMAX)) begin
         return SMAX;
      end else if (v < -(W+1)'(SMAX) - 1) begin
         return SMIN;
      end
      return v[W-1:0];
   endfunction

   // lane operand routing
   logic signed [W-1:0] lx [4][4], ly [4][4];
   logic [3:0] lneg [4];
   logic signed [W-1:0] p [4], q [4], m [4];
   qalu_pkg::kind_type kind;
   logic [W-1:0] lin [4];
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         p[n] = (cmd == qalu_pkg::CMD_BA_MUL) ? b[n] : a[n];
         q[n] = (cmd == qalu_pkg::CMD_BA_MUL) ? a[n] : b[n];
         m[n] = req_tuser[0] ? b[n] : a[n];
         lin[n] = '0;
         for (int t = 0; t < 4; t++) begin
            lx[n][t] = '0;
            ly[n][t] = '0;
         end
         lneg[n] = '0;
      end
      kind = qalu_pkg::KIND_ZERO;
      case (cmd)
         qalu_pkg::CMD_ADD, qalu_pkg::CMD_A_SUB, qalu_pkg::CMD_B_SUB: begin
            kind = qalu_pkg::KIND_LIN;
            for (int n = 0; n < 4; n++) begin
               if (cmd == qalu_pkg::CMD_ADD) lin[n] = sat1((W+1)'(a[n]) + (W+1)'(b[n]));
               else if (cmd == qalu_pkg::CMD_A_SUB) lin[n] = sat1((W+1)'(a[n]) - (W+1)'(b[n]));
               else lin[n] = sat1((W+1)'(b[n]) - (W+1)'(a[n]));
            end
         end
         qalu_pkg::CMD_CONJ_A, qalu_pkg::CMD_CONJ_B: begin
            kind = qalu_pkg::KIND_LIN;
            lin[0] = m[0];
            for (int n = 1; n < 4; n++) lin[n] = sat1(-(W+1)'(m[n]));
         end
         qalu_pkg::CMD_AB_MUL, qalu_pkg::CMD_BA_MUL: begin
            kind = qalu_pkg::KIND_PROD;
            lx[0] = '{p[0], p[1], p[2], p[3]}; ly[0] = '{q[0], q[1], q[2], q[3]};
            lneg[0] = 4'b1110;
            lx[1] = '{p[0], p[1], p[2], p[3]}; ly[1] = '{q[1], q[0], q[3], q[2]};
            lneg[1] = 4'b1000;
            lx[2] = '{p[0], p[1], p[2], p[3]}; ly[2] = '{q[2], q[3], q[0], q[1]};
            lneg[2] = 4'b0010;
            lx[3] = '{p[0], p[1], p[2], p[3]}; ly[3] = '{q[3], q[2], q[1], q[0]};
            lneg[3] = 4'b0100;
         end
         qalu_pkg::CMD_DOT: begin
            kind = qalu_pkg::KIND_DOT;
            lx[0] = '{a[0], a[1], a[2], a[3]}; ly[0] = '{b[0], b[1], b[2], b[3]};
         end
         qalu_pkg::CMD_SCL_A, qalu_pkg::CMD_SCL_B: begin
            kind = qalu_pkg::KIND_PROD;
            for (int n = 0; n < 4; n++) begin
               lx[n][0] = m[n];
               ly[n][0] = s;
            end
         end
         qalu_pkg::CMD_MAG_A, qalu_pkg::CMD_MAG_B: kind = qalu_pkg::KIND_MAG;
         qalu_pkg::CMD_INV_A, qalu_pkg::CMD_INV_B: kind = qalu_pkg::KIND_INV;
         default: kind = qalu_pkg::KIND_ZERO;
      endcase
   end

   // stage 0: operand registers for lanes and norm squares
   logic signed [W-1:0] lx_ff [4][4], ly_ff [4][4];
   logic [W:0]          mag_ff [4];
   logic [W-1:0]        lin_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         lx_ff <= lx;
         ly_ff <= ly;
         for (int n = 0; n < 4; n++) begin
            mag_ff[n] <= m[n][W-1] ? (W+1)'(-(W+1)'(m[n])) : (W+1)'(m[n]);
            lin_ff[n] <= lin[n];
         end
      end
   end

   ctl_type ctl_in;
   always_comb begin
      ctl_in.vld  = req_tvalid;
      ctl_in.kind = kind;
      ctl_in.lin0 = '0; ctl_in.lin1 = '0; ctl_in.lin2 = '0; ctl_in.lin3 = '0;
      ctl_in.big  = 1'b0;
      ctl_in.zero = 1'b0;
      ctl_in.neg  = {1'b0, 1'b0, 1'b0, 1'b0};
      ctl_in.nz   = '0;
      for (int n = 0; n < 4; n++) begin
         ctl_in.neg[n] = m[n][W-1] ^ (n != 0);
         ctl_in.nz[n]  = m[n] != '0;
      end
   end

   // stage 1: square each magnitude; stage 2: norm sum
   logic [2*W+1:0] sq_ff [4];
   logic [NW:0]    nrm_ff;
   logic [NW:0]    nrm_sum;
   always_comb begin
      nrm_sum = '0;
      for (int n = 0; n < 4; n++) nrm_sum = nrm_sum + (NW+1)'(sq_ff[n]);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) sq_ff[n] <= (2*W+2)'(mag_ff[n] * mag_ff[n]);
         nrm_ff <= nrm_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < LAT; t++) ctl_ff[t].vld <= 1'b0;
      end else if (adv) begin
         ctl_ff[0].vld <= ctl_in.vld;
         for (int t = 1; t < LAT; t++) ctl_ff[t].vld <= ctl_ff[t-1].vld;
      end
      if (adv) begin
         ctl_ff[0].kind <= ctl_in.kind;
         ctl_ff[0].neg  <= ctl_in.neg;
         ctl_ff[0].nz   <= ctl_in.nz;
         ctl_ff[0].lin0 <= '0; ctl_ff[0].lin1 <= '0;
         ctl_ff[0].lin2 <= '0; ctl_ff[0].lin3 <= '0;
         ctl_ff[0].big  <= 1'b0;
         ctl_ff[0].zero <= 1'b0;
         for (int t = 1; t < LAT; t++) begin
            ctl_ff[t].kind <= ctl_ff[t-1].kind;
            ctl_ff[t].neg  <= ctl_ff[t-1].neg;
            ctl_ff[t].nz   <= ctl_ff[t-1].nz;
            if (t != 1) begin
               ctl_ff[t].lin0 <= ctl_ff[t-1].lin0;
               ctl_ff[t].lin1 <= ctl_ff[t-1].lin1;
               ctl_ff[t].lin2 <= ctl_ff[t-1].lin2;
               ctl_ff[t].lin3 <= ctl_ff[t-1].lin3;
            end
            if (t != 3) begin
               ctl_ff[t].big  <= ctl_ff[t-1].big;
               ctl_ff[t].zero <= ctl_ff[t-1].zero;
            end
         end
         // fill linear results and norm flags once known
         ctl_ff[1].lin0 <= lin_ff[0]; ctl_ff[1].lin1 <= lin_ff[1];
         ctl_ff[1].lin2 <= lin_ff[2]; ctl_ff[1].lin3 <= lin_ff[3];
         ctl_ff[3].big  <= nrm_ff[2*W];
         ctl_ff[3].zero <= nrm_ff == '0;
      end
   end

   // product lanes; negation mask delayed to match product stage
   logic [3:0] lneg_ff [4], lneg_d_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         lneg_ff <= lneg;
         lneg_d_ff <= lneg_ff;
      end
   end
   logic signed [W-1:0] lane_sum [4];
   for (genvar g = 0; g < 4; g++) begin : g_lane
      qalu_lane #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .adv_0  (adv),
         .adv_1  (adv),
         .x      (lx_ff[g]),
         .y      (ly_ff[g]),
         .neg    (lneg_d_ff[g]),
         .sum_ff (lane_sum[g])
      );
   end
   // lanes finish at stage 2; delay to the end of the pipe
   localparam int LD = LAT - 3;
   logic [W-1:0] lsum_ff [4][LD];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) begin
            lsum_ff[n][0] <= lane_sum[n];
            for (int t = 1; t < LD; t++) lsum_ff[n][t] <= lsum_ff[n][t-1];
         end
      end
   end

   // norm feeds sqrt and dividers; magnitudes delayed to the divider start
   logic [W:0] magd_ff [4][2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) begin
            magd_ff[n][0] <= mag_ff[n];
            magd_ff[n][1] <= magd_ff[n][0];
         end
      end
   end

   logic [W:0] root;
   qalu_sqrt #(.WORD_WIDTH(W)) u_sqrt (
      .clock   (clock),
      .adv     (adv_v[SST-1:0]),
      .rad     (nrm_ff[NW-1:0]),
      .root_ff (root)
   );
   localparam int RD = LAT - 3 - SST;
   logic [W:0] root_ff [RD];
   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff[0] <= root;
         for (int t = 1; t < RD; t++) root_ff[t] <= root_ff[t-1];
      end
   end

   logic [W-1:0] quo [4];
   for (genvar g = 0; g < 4; g++) begin : g_div
      qalu_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .adv     (adv_v[DST-1:0]),
         .num     (magd_ff[g][1]),
         .den     (nrm_ff[NW-1:0] | NW'(nrm_ff == '0)),
         .quo_mag (quo[g])
      );
   end

   // merge stage
   ctl_type c;
   logic [W-1:0] r [4];
   logic [W-1:0] sc;
   logic err;
   always_comb begin
      logic [W:0] qv;
      c = ctl_ff[LAT-1];
      qv = '0;
      for (int n = 0; n < 4; n++) r[n] = '0;
      sc = '0;
      err = 1'b0;
      case (c.kind)
         qalu_pkg::KIND_LIN: begin
            r[0] = c.lin0; r[1] = c.lin1; r[2] = c.lin2; r[3] = c.lin3;
         end
         qalu_pkg::KIND_PROD: for (int n = 0; n < 4; n++) r[n] = lsum_ff[n][LD-1];
         qalu_pkg::KIND_DOT: sc = lsum_ff[0][LD-1];
         qalu_pkg::KIND_MAG: begin
            if (c.big || root_ff[RD-1] > (W+1)'(SMAX)) sc = SMAX;
            else sc = root_ff[RD-1][W-1:0];
         end
         qalu_pkg::KIND_INV: begin
            if (c.zero && !c.big) begin
               err = 1'b1;
            end else begin
               for (int n = 0; n < 4; n++) begin
                  // the divider also covers a norm of 2^64 exactly
                  qv = (W+1)'(quo[n]);
                  if (!c.nz[n]) r[n] = '0;
                  else if (c.neg[n]) r[n] = (qv > (W+1)'(SMAX) + 1) ? SMIN : W'(-qv);
                  else r[n] = (qv > (W+1)'(SMAX)) ? SMAX : qv[W-1:0];
               end
            end
         end
         default: sc = '0;
      endcase
   end

   assign rsp_tvalid = ctl_ff[LAT-1].vld;
   assign rsp_tdata  = {sc, r[3], r[2], r[1], r[0]};
   assign rsp_tuser  = err;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[4*W-1:0] == '0)
      else $error("error result carries data");
endmodule

@@ verif/quaternion_alu_checker.sv @@
// Checker for the quaternion ALU: watches both stream channels, predicts each
// result from the accepted request, and compares. Depends on qalu_pkg.
module quaternion_alu_checker (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tready,
   input  logic [287:0]   req_tdata,
   input  logic [3:0]     req_tuser,
   input  logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  logic [159:0]   rsp_tdata,
   input  logic           rsp_tuser,
   output int             fail_count,
   output int             pending
);
   typedef logic signed [129:0] wide_type;
   typedef struct {
      logic [159:0] words;
      logic         div_err;
   } qresult_type;

   localparam wide_type WMAX = 64'sd2147483647;
   localparam wide_type WMIN = -64'sd2147483648;

   qresult_type result_fifo[$];

   function automatic logic [31:0] clamp(wide_type v);
      if (v > WMAX) return WMAX[31:0];
      if (v < WMIN) return WMIN[31:0];
      return v[31:0];
   endfunction

   // Round to nearest, ties toward plus infinity, then saturate.
   function automatic logic [31:0] round_fx(wide_type s);
      return clamp((s + 32768) >>> 16);
   endfunction

   function automatic logic [63:0] root_round(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      if (x > res) res = res + 1;
      return res;
   endfunction

   function automatic wide_type norm_sq(wide_type q[4]);
      wide_type n;
      n = 0;
      for (int i = 0; i < 4; i++) n = n + q[i] * q[i];
      return n;
   endfunction

   // Magnitude rounds to nearest with ties away from zero, capped at all ones.
   function automatic logic [31:0] inv_part(wide_type x, logic negate, wide_type n);
      wide_type ux;
      wide_type qv;
      logic     neg;
      ux  = (x < 0) ? -x : x;
      neg = (x < 0) ^ negate;
      if (ux == 0) return 32'd0;
      qv = ((ux <<< 33) + n) / (n <<< 1);
      if (qv > 64'sd4294967295) qv = 64'sd4294967295;
      return clamp(neg ? -qv : qv);
   endfunction

   function automatic void hamilton(wide_type p[4], wide_type q[4],
                                    output logic [31:0] r[4]);
      r[0] = round_fx(p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3]);
      r[1] = round_fx(p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2]);
      r[2] = round_fx(p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1]);
      r[3] = round_fx(p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0]);
   endfunction

   function automatic qresult_type quat_compute(logic [3:0] code, logic [287:0] d);
      wide_type          a[4];
      wide_type          b[4];
      wide_type          q[4];
      wide_type          sf;
      wide_type          n;
      logic [31:0]       r[4];
      logic [31:0]       sc;
      logic [63:0]       m;
      qresult_type       res;
      qalu_pkg::cmd_type cmd;
      cmd = qalu_pkg::cmd_type'(code);
      for (int i = 0; i < 4; i++) begin
         a[i] = $signed(d[32*i +: 32]);
         b[i] = $signed(d[32*(i+4) +: 32]);
         q[i] = code[0] ? b[i] : a[i];
         r[i] = 0;
      end
      sf = $signed(d[256 +: 32]);
      sc = 0;
      res.div_err = 1'b0;
      case (cmd)
         qalu_pkg::CMD_ADD:    for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i]);
         qalu_pkg::CMD_A_SUB:  for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i]);
         qalu_pkg::CMD_B_SUB:  for (int i = 0; i < 4; i++) r[i] = clamp(b[i] - a[i]);
         qalu_pkg::CMD_AB_MUL: hamilton(a, b, r);
         qalu_pkg::CMD_BA_MUL: hamilton(b, a, r);
         qalu_pkg::CMD_DOT:
            sc = round_fx(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]);
         qalu_pkg::CMD_CONJ_A, qalu_pkg::CMD_CONJ_B: begin
            r[0] = q[0][31:0];
            for (int i = 1; i < 4; i++) r[i] = clamp(-q[i]);
         end
         qalu_pkg::CMD_MAG_A, qalu_pkg::CMD_MAG_B: begin
            n = norm_sq(q);
            if (n >= (wide_type'(1) <<< 64)) begin
               sc = WMAX[31:0];
            end else begin
               m = root_round(n[63:0]);
               sc = clamp(wide_type'({1'b0, m}));
            end
         end
         qalu_pkg::CMD_INV_A, qalu_pkg::CMD_INV_B: begin
            n = norm_sq(q);
            if (n == 0) res.div_err = 1'b1;
            else for (int i = 0; i < 4; i++) r[i] = inv_part(q[i], i != 0, n);
         end
         qalu_pkg::CMD_SCL_A, qalu_pkg::CMD_SCL_B:
            for (int i = 0; i < 4; i++) r[i] = round_fx(q[i] * sf);
         default: ;
      endcase
      res.words = {sc, r[3], r[2], r[1], r[0]};
      return res;
   endfunction

   always @(posedge clock) begin
      qresult_type exp_res;
      string       names[5];
      int          errs;
      names = '{"r_real", "r_i", "r_j", "r_k", "scalar_out"};
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) result_fifo.push_back(quat_compute(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (result_fifo.size() == 0) begin
               $error("unexpected result transfer");
               errs = errs + 1;
            end else begin
               exp_res = result_fifo.pop_front();
               for (int i = 0; i < 5; i++)
                  if (rsp_tdata[32*i +: 32] !== exp_res.words[32*i +: 32]) begin
                     $error("%s expected %h actual %h", names[i],
                            exp_res.words[32*i +: 32], rsp_tdata[32*i +: 32]);
                     errs = errs + 1;
                  end
               if (rsp_tuser !== exp_res.div_err) begin
                  $error("div_error expected %b actual %b", exp_res.div_err, rsp_tuser);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= result_fifo.size();
      end
   end

endmodule

@@ verif/quaternion_alu_tb.sv @@
// Top of the quaternion ALU testbench: clock, reset, request stimulus and
// response back-pressure. Depends on qalu_pkg, quaternion_alu, the checker.
module quaternion_alu_tb;
   localparam int STALL_LIMIT = 5000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [287:0]  req_tdata = '0;
   logic [3:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [159:0]  rsp_tdata;
   logic          rsp_tuser;
   int            fail_count;
   int            pending;
   logic          calm = 1'b0;
   int            quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   quaternion_alu i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   quaternion_alu_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= 19);

   // End the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom_range(32'h0010_0000) * ($urandom_range(1) ? 1 : -1);
         4: return 32'h0001_0000 * ($urandom_range(1) ? 1 : -1);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(logic [3:0] cmd, logic [31:0] w[9]);
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      for (int i = 0; i < 9; i++) req_tdata[32*i +: 32] <= w[i];
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [31:0] w[9];
      logic [3:0]  cmd;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every command with random operands, then the corner cases.
      for (int c = 0; c < 16; c++) begin
         for (int i = 0; i < 9; i++) w[i] = pick_word();
         send_item(4'(c), w);
      end
      w = '{default: 32'h7fff_ffff};
      send_item(qalu_pkg::CMD_ADD, w);
      send_item(qalu_pkg::CMD_SCL_A, w);
      w = '{default: 32'h8000_0000};
      send_item(qalu_pkg::CMD_A_SUB,
                '{32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0});
      send_item(qalu_pkg::CMD_MAG_A, w);
      send_item(qalu_pkg::CMD_INV_B, w);
      send_item(qalu_pkg::CMD_CONJ_A, w);
      send_item(qalu_pkg::CMD_SCL_B, w);
      send_item(qalu_pkg::CMD_AB_MUL, w);
      w = '{default: 32'h0};
      send_item(qalu_pkg::CMD_INV_A, w);
      send_item(qalu_pkg::CMD_INV_B, '{0, 0, 0, 0, 0, 0, 0, 1, 0});

      for (int n = 0; n < 1700; n++) begin
         calm <= (n >= 600 && n < 900);
         cmd = $urandom_range(15);
         for (int i = 0; i < 9; i++) w[i] = pick_word();
         // Hit the zero-norm inverse now and then.
         if ((cmd == qalu_pkg::CMD_INV_A || cmd == qalu_pkg::CMD_INV_B) &&
             $urandom_range(3) == 0)
            for (int i = 0; i < 4; i++) w[i + (cmd[0] ? 4 : 0)] = 0;
         send_item(cmd, w);
      end
      req_tvalid <= 1'b0;
      calm <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
